>>> rtl/core/nmeafr_pkg.sv
// Shared types and field widths for the NMEA sentence framer.
package nmeafr_pkg;

    localparam int LEN_W  = 11;
    localparam int SKIP_W = 16;
    localparam int MS_W   = 44;
    localparam int TIME_W = 64;

    // One finished (or dropped) sentence handed from the framer to the timing back end
    typedef struct packed {
        logic [LEN_W-1:0]  sentence_length;
        logic [SKIP_W-1:0] skipped_bytes;
        logic              epoch_found;
        logic [MS_W-1:0]   epoch_ms;
        logic              overlong;
    } job_t;

    // One result beat as presented on the output queue
    typedef struct packed {
        logic [LEN_W-1:0]  sentence_length;
        logic [SKIP_W-1:0] skipped_bytes;
        logic              epoch_found;
        logic [TIME_W-1:0] relative_time_ns;
        logic              time_clamped;
        logic              overlong;
    } result_t;

endpackage

>>> rtl/core/nmeafr_fifo.sv
// Small register-based synchronous FIFO with occupancy count.
module nmeafr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         pop,
    output logic [WIDTH-1:0]             rd_data,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && (count_reg != CNT_W'(DEPTH));
    assign do_pop  = pop && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/core/nmeafr_front.sv
// Byte framer: header hunt, sentence bounds, offset and digit-run epoch parsers.
module nmeafr_front #(
    parameter int MAX_SENTENCE_LEN = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               beat,
    input  logic [7:0]         data_byte,
    output logic               job_push,
    output nmeafr_pkg::job_t   job
);
    import nmeafr_pkg::*;

    localparam int POS_W = $clog2(MAX_SENTENCE_LEN + 2);
    localparam int SUM_W = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;
    localparam int ACC_W = 45;

    localparam logic [POS_W-1:0] POS_LIMIT  = POS_W'(MAX_SENTENCE_LEN + 1);
    localparam logic [POS_W-1:0] POS_COMMA  = POS_W'(6);
    localparam logic [ACC_W-1:0] EPOCH_LO   = 45'd1000000000000;
    localparam logic [ACC_W-1:0] EPOCH_HI   = 45'd10000000000000;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_BODY    = 4'b0100,
        PH_BODY_CR = 4'b1000
    } phase_t;

    typedef enum logic [3:0] {
        OS_IDLE   = 4'b0001,
        OS_SIGN   = 4'b0010,
        OS_DIGITS = 4'b0100,
        OS_DONE   = 4'b1000
    } ostat_t;

    // acc*10 + d, saturating at all ones
    function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                   input logic [3:0] d);
        logic [ACC_W+3:0] sum;
        sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{ACC_W{1'b0}}, d};
        return (|sum[ACC_W+3:ACC_W]) ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    endfunction

    function automatic logic in_range(input logic [ACC_W-1:0] v);
        return (v > EPOCH_LO) && (v < EPOCH_HI);
    endfunction

    function automatic logic [SKIP_W-1:0] sat_add(input logic [SKIP_W-1:0] s,
                                                  input logic [2:0] n);
        logic [SKIP_W:0] sum;
        sum = {1'b0, s} + {{(SKIP_W-2){1'b0}}, n};
        return sum[SKIP_W] ? {SKIP_W{1'b1}} : sum[SKIP_W-1:0];
    endfunction

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next;
    logic [POS_W-1:0]   rem_off_reg, rem_off_next;
    logic [ACC_W-1:0]   off_acc_reg, off_acc_next;
    ostat_t             off_st_reg, off_st_next;
    logic [ACC_W-1:0]   run_acc_reg, run_acc_next;
    logic [POS_W-1:0]   run_start_reg, run_start_next;
    logic               run_active_reg, run_active_next;
    logic [MS_W-1:0]    fe_val_reg, fe_val_next;
    logic [POS_W-1:0]   fe_off_reg, fe_off_next;
    logic               fe_valid_reg, fe_valid_next;

    logic               dig;
    logic [3:0]         digit;
    logic               is_dollar;
    logic               is_letter;
    logic [ACC_W-1:0]   off_step;
    logic [ACC_W-1:0]   run_step;
    logic               hdr_ok;
    logic               off_ok;
    logic [SUM_W-1:0]   len_full;
    logic               apply_parse;
    logic               start_hdr;

    // parse results for the current byte, before deciding whether to apply them
    ostat_t             p_off_st;
    logic [ACC_W-1:0]   p_off_acc;
    logic [ACC_W-1:0]   p_run_acc;
    logic [POS_W-1:0]   p_run_start;
    logic               p_run_active;
    logic [MS_W-1:0]    p_fe_val;
    logic [POS_W-1:0]   p_fe_off;
    logic               p_fe_valid;

    assign dig       = (data_byte >= CH_0) && (data_byte <= CH_9);
    assign digit     = dig ? data_byte[3:0] : 4'd0;
    assign is_dollar = (data_byte == CH_DOLLAR);
    assign is_letter = (data_byte >= CH_A) && (data_byte <= CH_Z);
    assign off_step  = acc_digit(off_acc_reg, digit);
    assign run_step  = acc_digit(run_acc_reg, digit);
    assign hdr_ok    = (pos_reg < POS_COMMA) ? is_letter : (data_byte == CH_COMMA);
    assign off_ok    = ((off_st_reg == OS_DIGITS) || (off_st_reg == OS_DONE))
                       && in_range(off_acc_reg);
    assign len_full  = SUM_W'(pos_reg) + SUM_W'(1);

    // offset parser and digit-run scanner
    always_comb
    begin
        p_off_st     = off_st_reg;
        p_off_acc    = off_acc_reg;
        p_run_acc    = run_acc_reg;
        p_run_start  = run_start_reg;
        p_run_active = run_active_reg;
        p_fe_val     = fe_val_reg;
        p_fe_off     = fe_off_reg;
        p_fe_valid   = fe_valid_reg;

        unique case (off_st_reg)
            OS_IDLE:
            begin
                if ((rem_off_reg != '0) && (pos_reg == rem_off_reg))
                begin
                    if (dig)
                    begin
                        p_off_acc = ACC_W'(digit);
                        p_off_st  = OS_DIGITS;
                    end
                    else if (data_byte == CH_PLUS)
                    begin
                        p_off_st = OS_SIGN;
                    end
                    else
                    begin
                        p_off_acc = '0;
                        p_off_st  = OS_DONE;
                    end
                end
            end
            OS_SIGN:
            begin
                if (dig)
                begin
                    p_off_acc = ACC_W'(digit);
                    p_off_st  = OS_DIGITS;
                end
                else
                begin
                    p_off_acc = '0;
                    p_off_st  = OS_DONE;
                end
            end
            OS_DIGITS:
            begin
                if (dig)
                begin
                    p_off_acc = off_step;
                end
                else
                begin
                    p_off_st = OS_DONE;
                end
            end
            OS_DONE:
            begin
                p_off_st = OS_DONE;
            end
            default:
            begin
                p_off_st = OS_DONE;
            end
        endcase

        if (dig)
        begin
            if (!run_active_reg)
            begin
                p_run_active = 1'b1;
                p_run_start  = pos_reg;
                p_run_acc    = ACC_W'(digit);
            end
            else
            begin
                p_run_acc = run_step;
            end
        end
        else if (run_active_reg)
        begin
            p_run_active = 1'b0;
            if (!fe_valid_reg && in_range(run_acc_reg))
            begin
                p_fe_valid = 1'b1;
                p_fe_val   = run_acc_reg[MS_W-1:0];
                p_fe_off   = run_start_reg;
            end
        end
    end

    // framing state machine
    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        skip_next       = skip_reg;
        rem_off_next    = rem_off_reg;
        off_acc_next    = off_acc_reg;
        off_st_next     = off_st_reg;
        run_acc_next    = run_acc_reg;
        run_start_next  = run_start_reg;
        run_active_next = run_active_reg;
        fe_val_next     = fe_val_reg;
        fe_off_next     = fe_off_reg;
        fe_valid_next   = fe_valid_reg;
        apply_parse     = 1'b0;
        start_hdr       = 1'b0;
        job_push        = 1'b0;
        job             = '0;

        if (beat)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (is_dollar)
                    begin
                        start_hdr = 1'b1;
                    end
                    else
                    begin
                        skip_next = sat_add(skip_reg, 3'd1);
                    end
                end
                PH_HEADER:
                begin
                    if (hdr_ok)
                    begin
                        apply_parse = 1'b1;
                        pos_next    = pos_reg + POS_W'(1);
                        if (pos_reg >= POS_COMMA)
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                    else
                    begin
                        // header bytes so far are dropped, plus this byte unless it is '$'
                        skip_next = sat_add(skip_reg, pos_reg[2:0] + {2'b0, !is_dollar});
                        if (is_dollar)
                        begin
                            start_hdr = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                end
                PH_BODY, PH_BODY_CR:
                begin
                    if ((phase_reg == PH_BODY_CR) && (data_byte == CH_LF))
                    begin
                        // end of sentence: pick the epoch source
                        job_push             = 1'b1;
                        job.sentence_length  = len_full[LEN_W-1:0];
                        job.skipped_bytes    = skip_reg;
                        job.epoch_found      = off_ok || fe_valid_reg;
                        job.epoch_ms         = off_ok ? off_acc_reg[MS_W-1:0] : fe_val_reg;
                        job.overlong         = 1'b0;
                        if (!off_ok && fe_valid_reg)
                        begin
                            rem_off_next = fe_off_reg;
                        end
                        skip_next  = '0;
                        phase_next = PH_HUNT;
                        pos_next   = '0;
                    end
                    else if (pos_reg >= POS_LIMIT)
                    begin
                        // too long: drop it, then treat this byte as a hunt byte
                        job_push      = 1'b1;
                        job.skipped_bytes = skip_reg;
                        job.overlong  = 1'b1;
                        pos_next      = '0;
                        if (is_dollar)
                        begin
                            skip_next = '0;
                            start_hdr = 1'b1;
                        end
                        else
                        begin
                            skip_next  = SKIP_W'(1);
                            phase_next = PH_HUNT;
                        end
                    end
                    else
                    begin
                        apply_parse = 1'b1;
                        pos_next    = pos_reg + POS_W'(1);
                        phase_next  = (data_byte == CH_CR) ? PH_BODY_CR : PH_BODY;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        if (apply_parse)
        begin
            off_st_next     = p_off_st;
            off_acc_next    = p_off_acc;
            run_acc_next    = p_run_acc;
            run_start_next  = p_run_start;
            run_active_next = p_run_active;
            fe_val_next     = p_fe_val;
            fe_off_next     = p_fe_off;
            fe_valid_next   = p_fe_valid;
        end

        // '$' opens a new header and clears the per-sentence parsers
        if (start_hdr)
        begin
            phase_next      = PH_HEADER;
            pos_next        = POS_W'(1);
            off_acc_next    = '0;
            off_st_next     = OS_IDLE;
            run_acc_next    = '0;
            run_start_next  = '0;
            run_active_next = 1'b0;
            fe_val_next     = '0;
            fe_off_next     = '0;
            fe_valid_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            pos_reg        <= '0;
            skip_reg       <= '0;
            rem_off_reg    <= '0;
            off_acc_reg    <= '0;
            off_st_reg     <= OS_IDLE;
            run_acc_reg    <= '0;
            run_start_reg  <= '0;
            run_active_reg <= 1'b0;
            fe_val_reg     <= '0;
            fe_off_reg     <= '0;
            fe_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            skip_reg       <= skip_next;
            rem_off_reg    <= rem_off_next;
            off_acc_reg    <= off_acc_next;
            off_st_reg     <= off_st_next;
            run_acc_reg    <= run_acc_next;
            run_start_reg  <= run_start_next;
            run_active_reg <= run_active_next;
            fe_val_reg     <= fe_val_next;
            fe_off_reg     <= fe_off_next;
            fe_valid_reg   <= fe_valid_next;
        end
    end

endmodule

>>> rtl/core/nmeafr_back.sv
// Timing back end: ms-to-ns scaling, start time latch, relative time and result queue.
module nmeafr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  nmeafr_pkg::job_t     job,
    output logic                 job_pop,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [63:0]          cfg_data,
    input  logic                 pop,
    output logic                 empty,
    output nmeafr_pkg::result_t  result
);
    import nmeafr_pkg::*;

    localparam int OUT_DEPTH = 4;
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
    localparam int OCC_W     = CNT_W + 1;
    localparam int HALF_W    = MS_W / 2;
    localparam int PROD_W    = HALF_W + 20;
    localparam logic [19:0] MS_TO_NS = 20'd1000000;

    logic                 s1_v_reg;
    job_t                 s1_job_reg;
    logic [PROD_W-1:0]    s1_lo_reg;
    logic [PROD_W-1:0]    s1_hi_reg;
    logic                 s2_v_reg;
    job_t                 s2_job_reg;
    logic [TIME_W-1:0]    s2_ns_reg;
    logic [TIME_W-1:0]    start_time_reg, start_time_next;
    logic [TIME_W-1:0]    preset_reg;

    logic [CNT_W-1:0]     out_count;
    logic [OCC_W-1:0]     occupancy;
    logic [PROD_W-1:0]    lo_prod;
    logic [PROD_W-1:0]    hi_prod;
    logic [TIME_W-1:0]    ns_sum;
    logic [TIME_W-1:0]    eff_start;
    logic [TIME_W:0]      diff;
    logic                 out_push;
    result_t              res;
    logic [$bits(result_t)-1:0] res_bits;
    logic [$bits(result_t)-1:0] head_bits;

    function automatic logic [TIME_W-1:0] hi_prod_shift(input logic [PROD_W-1:0] h);
        return TIME_W'({h, {HALF_W{1'b0}}});
    endfunction

    assign cfg_ready = 1'b1;

    // take a job only when the result queue has room for everything in flight
    assign occupancy = OCC_W'(out_count) + OCC_W'(s1_v_reg) + OCC_W'(s2_v_reg);
    assign job_pop   = job_valid && (occupancy < OCC_W'(OUT_DEPTH));

    // stage 1: split 44x20 multiply into two 22x20 halves
    assign lo_prod = {{(PROD_W-HALF_W){1'b0}}, job.epoch_ms[HALF_W-1:0]}
                     * {{(PROD_W-20){1'b0}}, MS_TO_NS};
    assign hi_prod = {{(PROD_W-HALF_W){1'b0}}, job.epoch_ms[MS_W-1:HALF_W]}
                     * {{(PROD_W-20){1'b0}}, MS_TO_NS};

    // stage 2: combine halves
    assign ns_sum = {hi_prod_shift(s1_hi_reg)} + TIME_W'(s1_lo_reg);

    // stage 3: start time selection and relative time
    always_comb
    begin
        start_time_next = start_time_reg;
        eff_start       = start_time_reg;
        if (start_time_reg == '0)
        begin
            eff_start = (preset_reg != '0) ? preset_reg : s2_ns_reg;
        end
        diff = {1'b0, s2_ns_reg} - {1'b0, eff_start};

        res                  = '0;
        res.sentence_length  = s2_job_reg.sentence_length;
        res.skipped_bytes    = s2_job_reg.skipped_bytes;
        res.epoch_found      = s2_job_reg.epoch_found;
        res.overlong         = s2_job_reg.overlong;
        if (s2_job_reg.epoch_found)
        begin
            res.time_clamped     = diff[TIME_W];
            res.relative_time_ns = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
            if (s2_v_reg && (start_time_reg == '0))
            begin
                start_time_next = eff_start;
            end
        end
    end

    assign out_push = s2_v_reg;
    assign res_bits = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
            start_time_reg <= '0;
            preset_reg     <= '0;
        end
        else
        begin
            s1_v_reg       <= job_pop;
            s2_v_reg       <= s1_v_reg;
            start_time_reg <= start_time_next;
            if (cfg_valid && cfg_ready)
            begin
                preset_reg <= cfg_data;
            end
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            s1_job_reg <= job;
            s1_lo_reg  <= lo_prod;
            s1_hi_reg  <= hi_prod;
        end
        if (s1_v_reg)
        begin
            s2_job_reg <= s1_job_reg;
            s2_ns_reg  <= ns_sum;
        end
    end

    nmeafr_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (res_bits),
        .pop     (pop),
        .rd_data (head_bits),
        .empty   (empty),
        .count   (out_count)
    );

    assign result = result_t'(head_bits);

    // credit scheme never pushes into a full result queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_count < CNT_W'(OUT_DEPTH)))
        else $error("result queue overflow");

    // once latched, the start time never changes
    a_start_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (start_time_reg != '0) |=> (start_time_reg == $past(start_time_reg)))
        else $error("start time changed after latch");

    // a clamped time only comes with a found epoch and reads as zero
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && res.time_clamped) |-> (res.epoch_found && (res.relative_time_ns == '0)))
        else $error("clamped result inconsistent");

    // a dropped sentence carries no length and no epoch
    a_overlong: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && res.overlong)
            |-> (!res.epoch_found && (res.sentence_length == '0) && !res.time_clamped))
        else $error("overlong result carries sentence data");

endmodule

>>> rtl/core/nmea_sentence_framer_timestamp_core.sv
// Top level of the NMEA sentence framer with millisecond-epoch timestamping.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------------
//   input    | in        | push / full         | data_byte
//   result   | out       | pop / empty         | sentence_length .. overlong
//   config   | in        | cfg_valid/cfg_ready | cfg_data (start_time_preset_ns)
//
// One byte is taken every clock while full is low; full rises only while the
// two-entry job queue between framer and timing back end is full.
// A result passes the job queue, the multiply stage and the sum stage on its way
// from the LF beat to the result queue (the subtract feeds the queue directly); the back end
// issues a job only when the four-entry result queue has room for all work in flight.
// Reset clears all control state; there is no clearing pass. cfg_ready is always high.
module nmea_sentence_framer_timestamp_core #(
    parameter int MAX_SENTENCE_LEN = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [7:0]   data_byte,
    output logic         empty,
    input  logic         pop,
    output logic [10:0]  sentence_length,
    output logic [15:0]  skipped_bytes,
    output logic         epoch_found,
    output logic [63:0]  relative_time_ns,
    output logic         time_clamped,
    output logic         overlong,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [63:0]  cfg_data
);
    import nmeafr_pkg::*;

    localparam int JOB_DEPTH = 2;
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    logic                    beat;
    logic                    job_push;
    job_t                    job_in;
    job_t                    job_out;
    logic [$bits(job_t)-1:0] job_wr_bits;
    logic [$bits(job_t)-1:0] job_rd_bits;
    logic                    job_empty;
    logic                    job_pop;
    logic [JOB_CNT_W-1:0]    job_count;
    result_t                 result;

    assign full        = (job_count == JOB_CNT_W'(JOB_DEPTH));
    assign beat        = push && !full;
    assign job_wr_bits = job_in;
    assign job_out     = job_t'(job_rd_bits);

    nmeafr_front #(
        .MAX_SENTENCE_LEN (MAX_SENTENCE_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .data_byte (data_byte),
        .job_push  (job_push),
        .job       (job_in)
    );

    nmeafr_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .wr_data (job_wr_bits),
        .pop     (job_pop),
        .rd_data (job_rd_bits),
        .empty   (job_empty),
        .count   (job_count)
    );

    nmeafr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    // result fields
    assign sentence_length  = result.sentence_length;
    assign skipped_bytes    = result.skipped_bytes;
    assign epoch_found      = result.epoch_found;
    assign relative_time_ns = result.relative_time_ns;
    assign time_clamped     = result.time_clamped;
    assign overlong         = result.overlong;

endmodule
